### hdl/assert_macros.svh
// Assertion helper macros shared by the wrapper RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/gww_pkg.sv
// Package for the greedy word wrapper: widths, character codes, state types.
// No dependencies; imported by every module of the wrapper.
package gww_pkg;

   localparam int BYTE_W            = 8;
   localparam int LINE_W_W          = 6;
   localparam int RUN_W             = 2;
   localparam int MAX_WIDTH_DEFAULT = 60;
   localparam logic [LINE_W_W-1:0] LINE_WIDTH_RESET = 6'd60;

   localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;
   localparam logic [BYTE_W-1:0] CHAR_TAB = 8'd9;
   localparam logic [BYTE_W-1:0] CHAR_NL  = 8'd10;
   localparam logic [BYTE_W-1:0] CHAR_SP  = 8'd32;

   localparam logic [RUN_W-1:0] RUN_BREAK = 2'd2;

   // Emission sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_PRE,
      S_RD,
      S_WORD,
      S_EXTRA,
      S_SUF
   } state_type;

   // Separator sent ahead of a flushed word
   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_NL,
      PRE_SP
   } prefix_type;

endpackage

### hdl/gww_word_ram.sv
// Word buffer memory: one write port, one registered read port.
// Depends on gww_pkg for the byte width.
module gww_word_ram #(
   parameter int DEPTH  = gww_pkg::MAX_WIDTH_DEFAULT,
   parameter int ADDR_W = 6
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [gww_pkg::BYTE_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [gww_pkg::BYTE_W-1:0] rd_data
);
   import gww_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/greedy_word_wrapper.sv
// Greedy word wrapper, top level. Depends on gww_pkg, gww_word_ram and assert_macros.svh.
// Text bytes come in one request at a time; the current word is kept in a MAX_WIDTH-entry
// byte memory and flushed onto the current line (after one space) when a space, tab,
// NUL, newline or end marker ends it, with a newline first when it would overflow the
// configured width. A request that only stores a word byte, or emits nothing, leaves the
// block idle, so the next request can be taken in the following cycle. A request that
// emits bytes holds req_stall while it sends each separator, newline, streamed byte and
// buffered word byte, and for as long as rsp_stall holds the result back; each word byte
// is fetched from the word memory through its registered read port (state S_RD, then
// S_WORD) before it goes out. The result register parts the two channels, so a new
// request may be taken while the last result still waits on rsp_stall.
// line_width must be written through the csr port only while the block is idle; the
// block itself does not enforce it. 0 acts as 1 and values above MAX_WIDTH act as
// MAX_WIDTH.
`include "assert_macros.svh"

module greedy_word_wrapper #(
   parameter int MAX_WIDTH = gww_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [gww_pkg::BYTE_W-1:0]   req_in_byte,
   input  logic                         req_end_of_input,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [gww_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_last_of_run,
   output logic                         rsp_overlong_seen,
   // configuration write
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [gww_pkg::LINE_W_W-1:0] csr_line_width
);
   import gww_pkg::*;

   // Counts must hold MAX_WIDTH itself; addresses only MAX_WIDTH-1
   localparam int CNT_W  = $clog2(MAX_WIDTH + 1);
   localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   // Architectural state
   logic [LINE_W_W-1:0] lw_ff;
   logic [CNT_W-1:0]    wc_ff, wc_in;
   logic [CNT_W-1:0]    col_ff, col_in;
   logic [RUN_W-1:0]    run_ff, run_in;
   logic                brk_ff, brk_in;
   logic                ovl_ff, ovl_in;
   logic                fail_ff, fail_in;

   // Emission plan for the request in flight
   prefix_type          pre_ff, pre_in;
   logic [CNT_W-1:0]    word_n_ff, word_n_in;
   logic                extra_ff, extra_in;
   logic [BYTE_W-1:0]   extra_byte_ff;
   logic [1:0]          suf_ff, suf_in;
   logic [ADDR_W-1:0]   idx_ff;

   state_type           state_ff, state_in;

   // Result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic                rsp_last_ff;
   logic                rsp_fail_ff;

   logic                accept;
   logic                is_sep;
   logic                store_t;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [BYTE_W-1:0]   ram_rd_data;
   logic [CNT_W-1:0]    w_eff;
   logic [CNT_W:0]      fit_sum;
   logic                out_free;
   logic                emit;
   logic [BYTE_W-1:0]   emit_byte;
   logic                emit_last;
   logic                word_end;

   // Phase that follows the word bytes
   function automatic state_type phase_after_word(input logic extra, input logic [1:0] suf);
      state_type s;
      if (extra) begin
         s = S_EXTRA;
      end else if (suf != 2'd0) begin
         s = S_SUF;
      end else begin
         s = S_IDLE;
      end
      return s;
   endfunction

   // Take one request only while no emission is running
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Clamp the configured width into 1..MAX_WIDTH
   always_comb begin
      if (lw_ff == '0) begin
         w_eff = CNT_W'(1);
      end else if (lw_ff > LINE_W_W'(MAX_WIDTH)) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = lw_ff[CNT_W-1:0];
      end
   end

   assign is_sep  = req_in_byte inside {CHAR_SP, CHAR_TAB, CHAR_NUL, CHAR_NL};
   assign fit_sum = {1'b0, col_ff} + {1'b0, wc_ff} + (CNT_W + 1)'(1);

   // Work out the whole output of a request and the state it leaves behind
   always_comb begin
      wc_in     = wc_ff;
      col_in    = col_ff;
      run_in    = run_ff;
      brk_in    = brk_ff;
      ovl_in    = ovl_ff;
      fail_in   = fail_ff;
      pre_in    = PRE_NONE;
      word_n_in = '0;
      extra_in  = 1'b0;
      suf_in    = 2'd0;
      store_t   = 1'b0;
      if (req_end_of_input || is_sep) begin
         // flush the pending word
         if (ovl_ff) begin
            suf_in = 2'd1;
            col_in = '0;
            ovl_in = 1'b0;
            wc_in  = '0;
            run_in = '0;
            brk_in = 1'b0;
         end else if (wc_ff != '0) begin
            word_n_in = wc_ff;
            if (wc_ff > w_eff) begin
               // word outgrew a shrunk width: own line, flag failure
               fail_in = 1'b1;
               pre_in  = (col_ff != '0) ? PRE_NL : PRE_NONE;
               suf_in  = 2'd1;
               col_in  = '0;
            end else if (col_ff == '0) begin
               col_in = wc_ff;
            end else if (fit_sum <= {1'b0, w_eff}) begin
               pre_in = PRE_SP;
               col_in = fit_sum[CNT_W-1:0];
            end else begin
               pre_in = PRE_NL;
               col_in = wc_ff;
            end
            wc_in  = '0;
            run_in = '0;
            brk_in = 1'b0;
         end
         if (req_end_of_input) begin
            // close the last line and start afresh
            if (col_in != '0) begin
               suf_in = suf_in + 2'd1;
            end
            col_in = '0;
            run_in = '0;
            brk_in = 1'b1;
         end else if (req_in_byte == CHAR_NL) begin
            if (run_in != RUN_BREAK) begin
               run_in = run_in + RUN_W'(1);
            end
            if (run_in == RUN_BREAK && !brk_in) begin
               // paragraph break: end the line, then one blank line
               suf_in = suf_in + 2'(col_in != '0) + 2'd1;
               col_in = '0;
               brk_in = 1'b1;
            end
         end
      end else if (ovl_ff) begin
         extra_in = 1'b1;
      end else if (wc_ff < w_eff) begin
         store_t = 1'b1;
         wc_in   = wc_ff + CNT_W'(1);
      end else begin
         // word overflows the width: dump it and stream the rest
         fail_in   = 1'b1;
         ovl_in    = 1'b1;
         pre_in    = (col_ff != '0) ? PRE_NL : PRE_NONE;
         word_n_in = wc_ff;
         extra_in  = 1'b1;
         wc_in     = '0;
         col_in    = w_eff;
      end
   end

   assign ram_wr_en = accept && store_t;
   assign ram_rd_en = (state_ff == S_RD);

   gww_word_ram #(
      .DEPTH  (MAX_WIDTH),
      .ADDR_W (ADDR_W)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wc_ff[ADDR_W-1:0]),
      .wr_data (req_in_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // Result register frees when empty or when its request is taken
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign word_end = (CNT_W'(idx_ff) == word_n_ff - CNT_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (pre_in != PRE_NONE) begin
                  state_in = S_PRE;
               end else if (word_n_in != '0) begin
                  state_in = S_RD;
               end else begin
                  state_in = phase_after_word(extra_in, suf_in);
               end
            end
         end
         S_PRE: begin
            if (out_free) begin
               state_in = (word_n_ff != '0) ? S_RD : phase_after_word(extra_ff, suf_ff);
            end
         end
         S_RD: begin
            state_in = S_WORD;
         end
         S_WORD: begin
            if (out_free) begin
               state_in = word_end ? phase_after_word(extra_ff, suf_ff) : S_RD;
            end
         end
         S_EXTRA: begin
            if (out_free) begin
               state_in = (suf_ff != 2'd0) ? S_SUF : S_IDLE;
            end
         end
         S_SUF: begin
            if (out_free && suf_ff == 2'd1) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Byte to send in the current phase and whether it closes the run
   always_comb begin
      emit      = 1'b0;
      emit_byte = CHAR_NL;
      emit_last = 1'b0;
      case (state_ff)
         S_PRE: begin
            emit      = out_free;
            emit_byte = (pre_ff == PRE_SP) ? CHAR_SP : CHAR_NL;
            emit_last = (word_n_ff == '0) && !extra_ff && (suf_ff == 2'd0);
         end
         S_WORD: begin
            emit      = out_free;
            emit_byte = ram_rd_data;
            emit_last = word_end && !extra_ff && (suf_ff == 2'd0);
         end
         S_EXTRA: begin
            emit      = out_free;
            emit_byte = extra_byte_ff;
            emit_last = (suf_ff == 2'd0);
         end
         S_SUF: begin
            emit      = out_free;
            emit_byte = CHAR_NL;
            emit_last = (suf_ff == 2'd1);
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = out_free ? emit : rsp_valid_ff;

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         lw_ff        <= LINE_WIDTH_RESET;
         wc_ff        <= '0;
         col_ff       <= '0;
         run_ff       <= '0;
         brk_ff       <= 1'b1;
         ovl_ff       <= 1'b0;
         fail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            lw_ff <= csr_line_width;
         end
         if (accept) begin
            wc_ff   <= wc_in;
            col_ff  <= col_in;
            run_ff  <= run_in;
            brk_ff  <= brk_in;
            ovl_ff  <= ovl_in;
            fail_ff <= fail_in;
         end
      end
   end

   // Plan, counters and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         pre_ff        <= pre_in;
         word_n_ff     <= word_n_in;
         extra_ff      <= extra_in;
         extra_byte_ff <= req_in_byte;
         suf_ff        <= suf_in;
         idx_ff        <= '0;
      end else begin
         if (state_ff == S_WORD && out_free) begin
            idx_ff <= idx_ff + ADDR_W'(1);
         end
         if (state_ff == S_SUF && out_free) begin
            suf_ff <= suf_ff - 2'd1;
         end
      end
      if (emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_last_ff <= emit_last;
         rsp_fail_ff <= fail_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_byte_ff;
   assign rsp_last_of_run   = rsp_last_ff;
   assign rsp_overlong_seen = rsp_fail_ff;

   `ASSERT_NEXT(a_read_then_word, clock, reset, (state_ff == S_RD), (state_ff == S_WORD),
      "word byte sent without a memory read")
   `ASSERT_IMPLIES(a_suffix_nonzero, clock, reset, (state_ff == S_SUF), (suf_ff != 2'd0),
      "suffix phase with nothing left")
   `ASSERT_IMPLIES(a_store_when_idle, clock, reset, ram_wr_en, (state_ff == S_IDLE),
      "word memory written during emission")
   `ASSERT_NEXT(a_fail_sticky, clock, reset, fail_ff, fail_ff, "overlong flag cleared")
   `ASSERT_ALWAYS(a_count_range, clock, reset,
      (wc_ff <= CNT_W'(MAX_WIDTH) && col_ff <= CNT_W'(MAX_WIDTH)),
      "word or column count beyond maximum width")

endmodule
